// ----- design/split_step_phase_rotator_defines.svh -----
`ifndef SPLIT_STEP_PHASE_ROTATOR_DEFINES_SVH
`define SPLIT_STEP_PHASE_ROTATOR_DEFINES_SVH

// Same-cycle implication on clk, held off while rst_n is low.
`define SPSR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk, held off while rst_n is low.
`define SPSR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/spsr_pkg.sv -----
package spsr_pkg;

  // Grid and CORDIC sizing
  localparam int GRID_SIZE    = 256;
  localparam int CORDIC_STEPS = 24;
  localparam int LOG2_GRID    = $clog2(GRID_SIZE + 1) - 1;  // floor(log2)

  // Wavenumber and k^2 widths
  localparam int K_W   = $clog2(GRID_SIZE) + 1;
  localparam int KSQ_W = 2 * K_W + 2;

  // Phase multiplier operand width (33-bit signed covers both modes)
  localparam int MUL_W = 33;

  // Output rounding shifts
  localparam int SH_KICK  = 30;
  localparam int SH_DRIFT = SH_KICK + 3 * LOG2_GRID;
  localparam int ACC_W    = 66;
  localparam logic signed [ACC_W-1:0] RND_KICK  = ACC_W'(1) << (SH_KICK - 1);
  localparam logic signed [ACC_W-1:0] RND_DRIFT = ACC_W'(1) << (SH_DRIFT - 1);

  // CORDIC datapath
  localparam int CW = 34;
  localparam logic signed [CW-1:0] INV_GAIN = CW'(652032874);  // 1/gain, Q4.30
  localparam logic [31:0] QUARTER_HALF = 32'h2000_0000;        // 1/8 turn

  // atan(2^-i) in 2^-32 turns
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Queue between front and back
  localparam int QADDR_W = 2;
  localparam int QDEPTH  = 1 << QADDR_W;

  // Configuration register map
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE        = 2'd0,
    CFG_KICK_SCALE  = 2'd1,
    CFG_DRIFT_SCALE = 2'd2
  } cfg_idx_t;

  localparam logic MODE_DRIFT = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] kick_scale;
    logic        [31:0] drift_scale;
  } cfg_t;

  // One classified item waiting for rotation
  typedef struct packed {
    logic               drift;
    logic        [31:0] phase;
    logic signed [31:0] psi_re;
    logic signed [31:0] psi_im;
  } item_t;

  // One CORDIC pipeline stage
  typedef struct packed {
    logic        [1:0]    quad;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic signed [31:0]   re;
    logic signed [31:0]   im;
    logic                 drift;
  } cstage_t;

  // Grid index to signed wavenumber; an 8-bit input, so this is a small table
  function automatic logic signed [K_W-1:0] wavenumber(input logic [7:0] idx);
    int i;
    i = int'(idx) % GRID_SIZE;
    if (i < GRID_SIZE / 2) begin
      return K_W'(i);
    end
    return K_W'(i - GRID_SIZE);
  endfunction

endpackage

// ----- design/spsr_ifs.sv -----
interface spsr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] psi_re;
  logic signed [31:0] psi_im;
  logic signed [31:0] potential;
  logic        [7:0]  grid_x;
  logic        [7:0]  grid_y;
  logic        [7:0]  grid_z;

  modport source (output valid, psi_re, psi_im, potential, grid_x, grid_y, grid_z,
                  input ready);
  modport sink   (input valid, psi_re, psi_im, potential, grid_x, grid_y, grid_z,
                  output ready);
endinterface

interface spsr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_re;
  logic signed [31:0] out_im;

  modport source (output valid, out_re, out_im, input ready);
  modport sink   (input valid, out_re, out_im, output ready);
endinterface

interface spsr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [spsr_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/spsr_front.sv -----
`include "split_step_phase_rotator_defines.svh"

module spsr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  spsr_pkg::cfg_t    cfg,
  spsr_in_if.sink           in_bus,
  input  logic              q_full,
  output logic              q_push,
  output spsr_pkg::item_t   q_item
);

  logic f_adv;

  // stage 0: operands picked by mode
  logic                                f0_v_r;
  logic                                f0_drift_r;
  logic signed [spsr_pkg::MUL_W-1:0]   f0_a_r;
  logic signed [spsr_pkg::MUL_W-1:0]   f0_b_r;
  logic signed [31:0]                  f0_re_r;
  logic signed [31:0]                  f0_im_r;

  // stage 1: phase ready to queue
  logic            f1_v_r;
  spsr_pkg::item_t f1_item_r;
  spsr_pkg::item_t f1_item_nxt;

  logic                                  drift;
  logic signed [spsr_pkg::K_W-1:0]       kx, ky, kz;
  logic signed [2*spsr_pkg::K_W-1:0]     kx2, ky2, kz2;
  logic        [spsr_pkg::KSQ_W-1:0]     k2;
  logic signed [spsr_pkg::MUL_W-1:0]     a_nxt, b_nxt;
  logic signed [2*spsr_pkg::MUL_W-1:0]   prod;

  // both stages move together unless stage 1 is stuck on a full queue
  assign f_adv        = !f1_v_r || !q_full;
  assign in_bus.ready = f_adv;
  assign q_push       = f1_v_r && !q_full;
  assign q_item       = f1_item_r;

  // k^2 from wrapped grid indices
  assign drift = (cfg.mode == spsr_pkg::MODE_DRIFT);
  assign kx    = spsr_pkg::wavenumber(in_bus.grid_x);
  assign ky    = spsr_pkg::wavenumber(in_bus.grid_y);
  assign kz    = spsr_pkg::wavenumber(in_bus.grid_z);
  assign kx2   = (2*spsr_pkg::K_W)'(kx) * (2*spsr_pkg::K_W)'(kx);
  assign ky2   = (2*spsr_pkg::K_W)'(ky) * (2*spsr_pkg::K_W)'(ky);
  assign kz2   = (2*spsr_pkg::K_W)'(kz) * (2*spsr_pkg::K_W)'(kz);
  assign k2    = spsr_pkg::KSQ_W'($unsigned(kx2)) + spsr_pkg::KSQ_W'($unsigned(ky2))
               + spsr_pkg::KSQ_W'($unsigned(kz2));

  // signed x signed in kick, unsigned x unsigned in drift via zero extension
  always_comb begin
    if (drift) begin
      a_nxt = $signed({1'b0, cfg.drift_scale});
      b_nxt = $signed({{(spsr_pkg::MUL_W - spsr_pkg::KSQ_W){1'b0}}, k2});
    end else begin
      a_nxt = spsr_pkg::MUL_W'(cfg.kick_scale);
      b_nxt = spsr_pkg::MUL_W'(in_bus.potential);
    end
  end

  assign prod = f0_a_r * f0_b_r;

  always_comb begin
    f1_item_nxt.drift  = f0_drift_r;
    f1_item_nxt.phase  = prod[47:16];
    f1_item_nxt.psi_re = f0_re_r;
    f1_item_nxt.psi_im = f0_im_r;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_v_r <= 1'b0;
      f1_v_r <= 1'b0;
    end else if (f_adv) begin
      f0_v_r <= in_bus.valid;
      f1_v_r <= f0_v_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (f_adv) begin
      f0_drift_r <= drift;
      f0_a_r     <= a_nxt;
      f0_b_r     <= b_nxt;
      f0_re_r    <= in_bus.psi_re;
      f0_im_r    <= in_bus.psi_im;
      f1_item_r  <= f1_item_nxt;
    end
  end

  `SPSR_ASSERT_NXT(a_front_hold, f1_v_r && q_full, $stable(f1_item_r) && f1_v_r, "front item lost while queue full")

endmodule

// ----- design/spsr_queue.sv -----
`include "split_step_phase_rotator_defines.svh"

module spsr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  spsr_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output spsr_pkg::item_t head
);

  spsr_pkg::item_t                mem_r [spsr_pkg::QDEPTH];
  logic [spsr_pkg::QADDR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [spsr_pkg::QADDR_W:0]     count_r, count_nxt;

  assign full  = (count_r == (spsr_pkg::QADDR_W + 1)'(spsr_pkg::QDEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  assign count_nxt = count_r + (spsr_pkg::QADDR_W + 1)'(push)
                   - (spsr_pkg::QADDR_W + 1)'(pop);

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers wrap naturally at the power-of-two depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  `SPSR_ASSERT_IMP(a_q_no_underflow, count_r == '0, !pop, "pop from empty queue")
  `SPSR_ASSERT_IMP(a_q_no_overflow, full, !push, "push into full queue")

endmodule

// ----- design/spsr_back.sv -----
`include "split_step_phase_rotator_defines.svh"

module spsr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  spsr_pkg::item_t head,
  input  logic            q_empty,
  output logic            q_pop,
  spsr_out_if.source      out_bus
);

  localparam int N = spsr_pkg::CORDIC_STEPS;

  logic b_adv;

  // CORDIC pipeline: stage 0 holds the reduced angle, stage N the final vector
  logic [N:0]        v_r;
  spsr_pkg::cstage_t st_r [N+1];
  spsr_pkg::cstage_t st_init;

  // multiply stage
  logic               m_v_r, m_drift_r;
  logic signed [63:0] p_cr_r, p_si_r, p_ci_r, p_sr_r;

  // sum and round stage
  logic                              s_v_r, s_drift_r;
  logic signed [spsr_pkg::ACC_W-1:0] acc_re_r, acc_im_r;

  // output register
  logic               out_v_r;
  logic signed [31:0] out_re_r, out_im_r;

  logic [31:0]                       red_t;
  logic [31:0]                       red_z;
  logic signed [31:0]                c_w, s_w;
  logic signed [spsr_pkg::ACC_W-1:0] rnd_w;
  logic signed [spsr_pkg::ACC_W-1:0] sh_re, sh_im;

  function automatic logic signed [31:0] sat32(input logic signed [spsr_pkg::ACC_W-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[spsr_pkg::ACC_W-1:31];
    hi_zeros = ~|v[spsr_pkg::ACC_W-1:31];
    if (hi_ones || hi_zeros) begin
      return v[31:0];
    end else if (v[spsr_pkg::ACC_W-1]) begin
      return {1'b1, {31{1'b0}}};
    end
    return {1'b0, {31{1'b1}}};
  endfunction

  // whole back end stalls only when the output beat is not taken
  assign b_adv = !out_v_r || out_bus.ready;
  assign q_pop = b_adv && !q_empty;

  // quadrant and residual angle in [-1/8, 1/8) turn
  always_comb begin
    red_t         = head.phase + spsr_pkg::QUARTER_HALF;
    st_init.quad  = red_t[31:30];
    red_z         = head.phase - {red_t[31:30], 30'b0};
    st_init.z     = spsr_pkg::CW'($signed(red_z));
    st_init.x     = spsr_pkg::INV_GAIN;
    st_init.y     = '0;
    st_init.re    = head.psi_re;
    st_init.im    = head.psi_im;
    st_init.drift = head.drift;
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      st_r[0] <= st_init;
    end
  end

  // one rotation step per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [spsr_pkg::CW-1:0] xi, yi, zi, dx, dy, ang;
    spsr_pkg::cstage_t              nxt;

    assign xi  = st_r[i].x;
    assign yi  = st_r[i].y;
    assign zi  = st_r[i].z;
    assign dx  = yi >>> i;
    assign dy  = xi >>> i;
    assign ang = $signed(spsr_pkg::CW'(spsr_pkg::ATAN_TURNS[i]));

    always_comb begin
      nxt = st_r[i];
      if (!zi[spsr_pkg::CW-1]) begin
        nxt.x = xi - dx;
        nxt.y = yi + dy;
        nxt.z = zi - ang;
      end else begin
        nxt.x = xi + dx;
        nxt.y = yi - dy;
        nxt.z = zi + ang;
      end
    end

    always_ff @(posedge clk) begin
      if (b_adv) begin
        st_r[i+1] <= nxt;
      end
    end
  end

  // quadrant applied to the final vector
  always_comb begin
    case (st_r[N].quad)
      2'd0: begin
        c_w = st_r[N].x[31:0];
        s_w = st_r[N].y[31:0];
      end
      2'd1: begin
        c_w = -st_r[N].y[31:0];
        s_w = st_r[N].x[31:0];
      end
      2'd2: begin
        c_w = -st_r[N].x[31:0];
        s_w = -st_r[N].y[31:0];
      end
      default: begin
        c_w = st_r[N].y[31:0];
        s_w = -st_r[N].x[31:0];
      end
    endcase
  end

  // rounding bias follows the item in the multiply stage
  assign rnd_w = m_drift_r ? spsr_pkg::RND_DRIFT : spsr_pkg::RND_KICK;
  assign sh_re = acc_re_r;
  assign sh_im = acc_im_r;

  // datapath registers
  always_ff @(posedge clk) begin
    if (b_adv) begin
      p_cr_r    <= c_w * st_r[N].re;
      p_si_r    <= s_w * st_r[N].im;
      p_ci_r    <= c_w * st_r[N].im;
      p_sr_r    <= s_w * st_r[N].re;
      m_drift_r <= st_r[N].drift;

      acc_re_r  <= spsr_pkg::ACC_W'(p_cr_r) + spsr_pkg::ACC_W'(p_si_r) + rnd_w;
      acc_im_r  <= spsr_pkg::ACC_W'(p_ci_r) - spsr_pkg::ACC_W'(p_sr_r) + rnd_w;
      s_drift_r <= m_drift_r;

      if (s_drift_r) begin
        out_re_r <= sat32(sh_re >>> spsr_pkg::SH_DRIFT);
        out_im_r <= sat32(sh_im >>> spsr_pkg::SH_DRIFT);
      end else begin
        out_re_r <= sat32(sh_re >>> spsr_pkg::SH_KICK);
        out_im_r <= sat32(sh_im >>> spsr_pkg::SH_KICK);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      m_v_r   <= 1'b0;
      s_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else if (b_adv) begin
      v_r     <= {v_r[N-1:0], q_pop};
      m_v_r   <= v_r[N];
      s_v_r   <= m_v_r;
      out_v_r <= s_v_r;
    end
  end

  assign out_bus.valid  = out_v_r;
  assign out_bus.out_re = out_re_r;
  assign out_bus.out_im = out_im_r;

  `SPSR_ASSERT_NXT(a_back_stall, !b_adv, $stable(v_r) && $stable(s_v_r) && out_v_r, "back pipeline moved during stall")

endmodule

// ----- design/split_step_phase_rotator.sv -----
// Input beats pass the front stages, the queue, the CORDIC stages, the multiply,
// sum and round stages and the output register. Throughput: one beat per cycle,
// set by the fully pipelined CORDIC and multiply stages, unless the output stalls.
// A 4-entry queue lets the input side keep accepting while the output is held.
// Reset (rst_n low, synchronous) clears config registers to 0 and empties all stages.
module split_step_phase_rotator (
  input  logic       clk,
  input  logic       rst_n,
  spsr_in_if.sink    in_bus,
  spsr_out_if.source out_bus,
  spsr_cfg_if.sink   cfg_bus
);

  spsr_pkg::cfg_t  cfg_r, cfg_nxt;

  logic            q_push, q_full, q_pop, q_empty;
  spsr_pkg::item_t q_in, q_head;

  // configuration writes, always accepted
  assign cfg_bus.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_bus.valid) begin
      unique case (spsr_pkg::cfg_idx_t'(cfg_bus.index))
        spsr_pkg::CFG_MODE:        cfg_nxt.mode        = cfg_bus.data[0];
        spsr_pkg::CFG_KICK_SCALE:  cfg_nxt.kick_scale  = $signed(cfg_bus.data);
        spsr_pkg::CFG_DRIFT_SCALE: cfg_nxt.drift_scale = cfg_bus.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  spsr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_bus (in_bus),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in)
  );

  spsr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  spsr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_bus (out_bus)
  );

endmodule

// ----- dv/spsr_rotation_checker.sv -----
// Watches the three channels of the phase rotator, predicts the rotated wave value
// for every accepted input beat and compares it with the output beats in order.
module spsr_rotation_checker (
  input  logic       clk,
  input  logic       rst_n,
  spsr_in_if         in_mon,
  spsr_out_if        out_mon,
  spsr_cfg_if        cfg_mon,
  output int         mismatch_count,
  output int         cells_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint INV_GAIN_Q30 = 652032874;
  localparam int     KICK_SHIFT   = 30;
  localparam int     NORM_SHIFT   = 3 * ($clog2(spsr_pkg::GRID_SIZE + 1) - 1);
  localparam longint SAT_HI       = 64'sd2147483647;
  localparam longint SAT_LO       = -64'sd2147483648;

  // atan(2^-i) in 2^-32 turns
  localparam logic [0:31][31:0] ARCTAN = {
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } rotated_t;

  // Shadow copy of the register file
  logic               drift_mode;
  logic signed [31:0] kick_gain;
  logic        [31:0] drift_gain;

  rotated_t rotated_q[$];

  function automatic longint grid_wavenumber(input logic [7:0] idx);
    int i;
    i = int'(idx) % spsr_pkg::GRID_SIZE;
    return (i < spsr_pkg::GRID_SIZE / 2) ? longint'(i) : longint'(i - spsr_pkg::GRID_SIZE);
  endfunction

  function automatic logic signed [31:0] round_saturate(input longint acc, input int sh);
    longint r;
    r = (acc + (longint'(1) <<< (sh - 1))) >>> sh;
    if (r > SAT_HI) r = SAT_HI;
    if (r < SAT_LO) r = SAT_LO;
    return 32'(r);
  endfunction

  // Rotate one wave value by exp(-i*phase) under the current register settings
  function automatic rotated_t rotate_cell(input logic signed [31:0] re,
                                           input logic signed [31:0] im,
                                           input logic signed [31:0] pot,
                                           input logic [7:0] gx,
                                           input logic [7:0] gy,
                                           input logic [7:0] gz);
    logic signed [63:0] kprod;
    logic        [63:0] dprod;
    longint             kx, ky, kz;
    logic        [31:0] phase;
    logic        [31:0] shifted;
    logic        [1:0]  quad;
    longint             x, y, z, dx, dy, c, s;
    int                 sh;
    rotated_t           r;
    sh = KICK_SHIFT;
    if (drift_mode != spsr_pkg::MODE_DRIFT) begin
      kprod = longint'(kick_gain) * longint'(pot);
      phase = kprod[47:16];
    end else begin
      kx = grid_wavenumber(gx);
      ky = grid_wavenumber(gy);
      kz = grid_wavenumber(gz);
      dprod = {32'b0, drift_gain} * 64'(kx * kx + ky * ky + kz * kz);
      phase = dprod[47:16];
      sh = KICK_SHIFT + NORM_SHIFT;
    end
    // quadrant pick, residual in [-1/8, 1/8) turn
    shifted = phase + 32'h2000_0000;
    quad = shifted[31:30];
    z = longint'($signed(phase - {quad, 30'b0}));
    x = INV_GAIN_Q30;
    y = 0;
    for (int i = 0; i < spsr_pkg::CORDIC_STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ARCTAN[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ARCTAN[i]);
      end
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    r.re = round_saturate(c * re + s * im, sh);
    r.im = round_saturate(c * im - s * re, sh);
    return r;
  endfunction

  always @(posedge clk) begin
    rotated_t exp_val;
    if (!rst_n) begin
      drift_mode      = 1'b0;
      kick_gain       = '0;
      drift_gain      = '0;
      mismatch_count  = 0;
      rotated_q.delete();
      cells_in_flight = 0;
    end else begin
      // input beat: predict with the settings in force before this edge
      if (in_mon.valid && in_mon.ready) begin
        rotated_q.push_back(rotate_cell(in_mon.psi_re, in_mon.psi_im, in_mon.potential,
                                        in_mon.grid_x, in_mon.grid_y, in_mon.grid_z));
      end
      // output beat against oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        if (rotated_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected output beat re=%0d im=%0d", $time,
                   out_mon.out_re, out_mon.out_im);
        end else begin
          exp_val = rotated_q.pop_front();
          if (out_mon.out_re !== exp_val.re) begin
            mismatch_count++;
            $display("%0t: out_re expected %0d actual %0d", $time, exp_val.re,
                     out_mon.out_re);
          end
          if (out_mon.out_im !== exp_val.im) begin
            mismatch_count++;
            $display("%0t: out_im expected %0d actual %0d", $time, exp_val.im,
                     out_mon.out_im);
          end
        end
      end
      // register write beat
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          spsr_pkg::CFG_MODE:        drift_mode = cfg_mon.data[0];
          spsr_pkg::CFG_KICK_SCALE:  kick_gain  = cfg_mon.data;
          spsr_pkg::CFG_DRIFT_SCALE: drift_gain = cfg_mon.data;
          default: ;
        endcase
      end
      cells_in_flight = rotated_q.size();
    end
  end

endmodule

// ----- dv/tb_split_step_phase_rotator.sv -----
module tb_split_step_phase_rotator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [spsr_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
  localparam int STALL_LIMIT    = 2000;
  localparam int RAND_PHASES    = 10;
  localparam int CELLS_PER_PHASE = 130;
  localparam int TAIL_CYCLES    = spsr_pkg::CORDIC_STEPS + 16;

  logic clk;
  logic rst_n;
  bit   steady;
  int   mismatch_count;
  int   cells_in_flight;
  int   quiet_cycles;

  spsr_in_if  in_if ();
  spsr_out_if out_if ();
  spsr_cfg_if cfg_if ();

  split_step_phase_rotator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  spsr_rotation_checker rotation_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_if),
    .out_mon         (out_if),
    .cfg_mon         (cfg_if),
    .mismatch_count  (mismatch_count),
    .cells_in_flight (cells_in_flight)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output back-pressure, ~30% stall outside the steady stretch
  always @(negedge clk) begin
    out_if.ready <= steady || ($urandom_range(99) >= 30);
  end

  // Watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("split_step_phase_rotator test failed");
        $finish;
      end
    end
  end

  // Register write; leaves valid high so back-to-back writes need no toggle
  task automatic write_reg(input logic [spsr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [31:0] mode_word, input logic [31:0] kick,
                              input logic [31:0] drift, input bit poke_unused);
    write_reg(spsr_pkg::CFG_MODE, mode_word);
    write_reg(spsr_pkg::CFG_KICK_SCALE, kick);
    write_reg(spsr_pkg::CFG_DRIFT_SCALE, drift);
    if (poke_unused) write_reg(CFG_NO_REG, $urandom);
    cfg_if.valid <= 1'b0;
  endtask

  // One input beat, with idle cycles ahead of it at random
  task automatic push_cell(input logic [31:0] re, input logic [31:0] im,
                           input logic [31:0] pot, input logic [7:0] gx,
                           input logic [7:0] gy, input logic [7:0] gz);
    while (!steady && $urandom_range(99) < 30) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.psi_re    <= re;
    in_if.psi_im    <= im;
    in_if.potential <= pot;
    in_if.grid_x    <= gx;
    in_if.grid_y    <= gy;
    in_if.grid_z    <= gz;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic drain_cells();
    in_if.valid <= 1'b0;
    while (cells_in_flight != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] wave_sample();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'(int'($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] kick, drift;
    rst_n          = 1'b0;
    steady         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.psi_re   = '0;
    in_if.psi_im   = '0;
    in_if.potential = '0;
    in_if.grid_x   = '0;
    in_if.grid_y   = '0;
    in_if.grid_z   = '0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = spsr_pkg::CFG_MODE;
    cfg_if.data    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: zero phase, extreme wave values pass through
    push_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0, 8'd0, 8'd0);
    push_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'd255, 8'd255, 8'd255);
    push_cell(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 8'd128, 8'd127, 8'd1);
    push_cell(32'h0000_0001, 32'hFFFF_FFFF, 32'h1234_5678, 8'd7, 8'd200, 8'd64);
    drain_cells();

    // Kick, unit gain; wide mode word keeps only bit 0; unused index ignored
    program_regs(32'hFFFF_FFFE, 32'h0001_0000, 32'h0000_0000, 1'b1);
    push_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h2000_0000, 8'd0, 8'd0, 8'd0);  // 1/8 turn
    push_cell(32'h8000_0000, 32'h8000_0000, 32'h1FFF_FFFF, 8'd0, 8'd0, 8'd0);  // just under
    push_cell(32'h4000_0000, 32'h0000_0000, 32'h4000_0000, 8'd0, 8'd0, 8'd0);  // quarter
    push_cell(32'h4000_0000, 32'hC000_0000, 32'h6000_0000, 8'd0, 8'd0, 8'd0);  // 3/8
    push_cell(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 8'd0, 8'd0, 8'd0);  // half
    push_cell(32'h1234_5678, 32'h8765_4321, 32'hE000_0000, 8'd9, 8'd9, 8'd9);  // -1/8
    drain_cells();

    // Kick gain extremes
    program_regs(32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    push_cell(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 8'd0, 8'd0, 8'd0);
    push_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0, 8'd0, 8'd0);
    drain_cells();
    program_regs(32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
    push_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0, 8'd0, 8'd0);
    push_cell(32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 8'd0, 8'd0, 8'd0);
    drain_cells();

    // Drift, wide mode word, gain extremes, wavenumber wrap points
    program_regs(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    push_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0, 8'd0, 8'd0);
    push_cell(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 8'd127, 8'd127, 8'd127);
    push_cell(32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 8'd128, 8'd128, 8'd128);
    push_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 8'd255, 8'd1, 8'd129);
    drain_cells();
    program_regs(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_4000, 1'b0);
    push_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 8'd1, 8'd0, 8'd0);
    push_cell(32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 8'd255, 8'd255, 8'd0);
    push_cell(32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 8'd128, 8'd0, 8'd128);
    drain_cells();

    // Random phases, each under fresh settings
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(4))
        0:       kick = 32'h8000_0000;
        1:       kick = 32'h7FFF_FFFF;
        2:       kick = 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
        default: kick = $urandom;
      endcase
      case ($urandom_range(3))
        0:       drift = 32'hFFFF_FFFF;
        1:       drift = $urandom_range(0, 1 << 20);
        default: drift = $urandom;
      endcase
      program_regs({31'($urandom_range(32'h7FFF_FFFF)), 1'(ph % 2)}, kick, drift,
                   $urandom_range(3) == 0);
      steady = (ph == 4);
      for (int n = 0; n < CELLS_PER_PHASE; n++) begin
        push_cell(wave_sample(), wave_sample(), $urandom, 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
      end
      drain_cells();
      steady = 1'b0;
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && cells_in_flight == 0) begin
      $display("split_step_phase_rotator test passed");
    end else begin
      $display("split_step_phase_rotator test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/spsr_pkg.sv
design/spsr_ifs.sv
design/spsr_front.sv
design/spsr_queue.sv
design/spsr_back.sv
design/split_step_phase_rotator.sv
dv/spsr_rotation_checker.sv
dv/tb_split_step_phase_rotator.sv
